// ===== rtl/muscl_van_albada_face_values_core_defines.svh =====
// assertion helpers used by the core rtl file
`ifndef MUSCL_VAN_ALBADA_FACE_VALUES_CORE_DEFINES_SVH
`define MUSCL_VAN_ALBADA_FACE_VALUES_CORE_DEFINES_SVH

// checked outside reset only
`define MVAF_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
  else $error(msg);

// checked during reset as well
`define MVAF_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) \
  else $error(msg);

`endif

// ===== rtl/mvaf_pkg.sv =====
package mvaf_pkg;

  localparam int FRAC_BITS_DEF = 16;
  localparam int VAL_W         = 32;
  localparam int KAPPA_W       = 18;
  localparam int EPS_W         = 17;
  localparam int CFG_IDX_W     = 1;
  localparam int CFG_DATA_W    = 18;

  localparam logic [CFG_IDX_W-1:0] REG_KAPPA = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_EPS   = 1'b1;

  localparam logic signed [KAPPA_W-1:0] KAPPA_RST = 18'sd21845;
  localparam logic [EPS_W-1:0]          EPS_RST   = 17'd1;

  // clamp to the signed 32-bit range
  function automatic logic signed [VAL_W-1:0] sat_val(input logic signed [63:0] v);
    if (v > 64'sd2147483647) begin
      return 32'sh7fffffff;
    end else if (v < -64'sd2147483648) begin
      return 32'sh80000000;
    end else begin
      return v[VAL_W-1:0];
    end
  endfunction

endpackage

// ===== rtl/mvaf_side.sv =====
module mvaf_side #(
  parameter int FRAC_BITS = mvaf_pkg::FRAC_BITS_DEF
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic [FRAC_BITS+4:0]                 en_i,
  input  logic signed [mvaf_pkg::KAPPA_W-1:0]  kappa_i,
  input  logic [mvaf_pkg::EPS_W-1:0]           eps_i,
  input  logic signed [mvaf_pkg::VAL_W-1:0]    d_i,
  input  logic signed [mvaf_pkg::VAL_W:0]      du_i,
  output logic signed [((FRAC_BITS > 17) ? FRAC_BITS : 17) + 35 - FRAC_BITS:0] corr_o
);

  localparam int NW  = 66 - FRAC_BITS;
  localparam int WK  = ((FRAC_BITS > 17) ? FRAC_BITS : 17) + 2;
  localparam int SW  = WK + 34 - FRAC_BITS;
  localparam int KPW = mvaf_pkg::KAPPA_W + FRAC_BITS + 2;
  localparam int VW  = mvaf_pkg::VAL_W;
  localparam int ST_KP = FRAC_BITS + 2;
  localparam int ST_T  = FRAC_BITS + 3;
  localparam int ST_SP = FRAC_BITS + 4;
  localparam logic [FRAC_BITS:0]    ONE_PHI = (FRAC_BITS+1)'(64'd1 << FRAC_BITS);
  localparam logic signed [WK-1:0]  ONE_K   = WK'(64'd1 << FRAC_BITS);

  // magnitudes, their product and squares
  logic [VW-1:0] a_mag, b_mag;
  logic [63:0]   ab_q, aa_q, bb_q;
  logic          sgn_q;
  logic signed [VW-1:0] d0_q;
  logic signed [VW:0]   du0_q;

  assign a_mag = d_i[VW-1] ? VW'(~d_i) + 32'd1 : VW'(d_i);
  assign b_mag = du_i[VW] ? VW'(~du_i) + 32'd1 : du_i[VW-1:0];

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      ab_q  <= 64'(a_mag) * 64'(b_mag);
      aa_q  <= 64'(a_mag) * 64'(a_mag);
      bb_q  <= 64'(b_mag) * 64'(b_mag);
      sgn_q <= d_i[VW-1] ^ du_i[VW];
      d0_q  <= d_i;
      du0_q <= du_i;
    end
  end

  // limiter numerator and denominator
  logic          neg;
  logic [NW-1:0] nmag, eps_ext, num, den;
  logic          zero_c;

  assign neg     = (ab_q != 64'd0) && sgn_q;
  assign nmag    = NW'(ab_q >> (FRAC_BITS - 1));
  assign eps_ext = NW'(eps_i);
  assign den     = NW'(aa_q >> FRAC_BITS) + NW'(bb_q >> FRAC_BITS) + eps_ext;
  assign num     = neg ? (eps_ext - nmag) : (nmag + eps_ext);
  assign zero_c  = (neg && (nmag >= eps_ext)) || (den == '0);

  logic [NW-1:0]        rem_q  [FRAC_BITS+1];
  logic [NW-1:0]        den_q  [FRAC_BITS+1];
  logic [FRAC_BITS-1:0] quo_q  [FRAC_BITS+1];
  logic                 zero_q [FRAC_BITS+1];
  logic                 one_q  [FRAC_BITS+1];
  logic signed [VW-1:0] dd_q   [FRAC_BITS+1];
  logic signed [VW:0]   ddu_q  [FRAC_BITS+1];

  always_ff @(posedge clk_i) begin
    if (en_i[1]) begin
      rem_q[0]  <= num;
      den_q[0]  <= den;
      quo_q[0]  <= '0;
      zero_q[0] <= zero_c;
      one_q[0]  <= num >= den;
      dd_q[0]   <= d0_q;
      ddu_q[0]  <= du0_q;
    end
  end

  // restoring division, one quotient bit per stage
  for (genvar i = 1; i <= FRAC_BITS; i++) begin : g_div
    logic [NW:0] r2;
    logic        ge;
    assign r2 = {rem_q[i-1], 1'b0};
    assign ge = r2 >= {1'b0, den_q[i-1]};
    always_ff @(posedge clk_i) begin
      if (en_i[i+1]) begin
        rem_q[i]  <= ge ? NW'(r2 - {1'b0, den_q[i-1]}) : NW'(r2);
        den_q[i]  <= den_q[i-1];
        quo_q[i]  <= {quo_q[i-1][FRAC_BITS-2:0], ge};
        zero_q[i] <= zero_q[i-1];
        one_q[i]  <= one_q[i-1];
        dd_q[i]   <= dd_q[i-1];
        ddu_q[i]  <= ddu_q[i-1];
      end
    end
  end

  // limiter value and kappa weighting
  logic [FRAC_BITS:0]    phi, phi2_q, phi3_q;
  logic signed [KPW-1:0] kprod_q;
  logic signed [VW-1:0]  d2_q;
  logic signed [VW:0]    du2_q;

  always_comb begin
    priority if (zero_q[FRAC_BITS]) begin
      phi = '0;
    end else if (one_q[FRAC_BITS]) begin
      phi = ONE_PHI;
    end else begin
      phi = {1'b0, quo_q[FRAC_BITS]};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i[ST_KP]) begin
      kprod_q <= kappa_i * signed'({1'b0, phi});
      phi2_q  <= phi;
      d2_q    <= dd_q[FRAC_BITS];
      du2_q   <= ddu_q[FRAC_BITS];
    end
  end

  logic signed [KPW-FRAC_BITS-1:0] kp;
  logic signed [WK-1:0]            omk, opk;
  logic signed [WK+VW-1:0]         t1_q;
  logic signed [WK+VW:0]           t2_q;

  assign kp  = kprod_q[KPW-1:FRAC_BITS];
  assign omk = ONE_K - WK'(kp);
  assign opk = ONE_K + WK'(kp);

  always_ff @(posedge clk_i) begin
    if (en_i[ST_T]) begin
      t1_q   <= omk * d2_q;
      t2_q   <= opk * du2_q;
      phi3_q <= phi2_q;
    end
  end

  logic signed [SW-1:0]          s_sum;
  logic signed [SW+FRAC_BITS+1:0] sp_q;

  assign s_sum = SW'(t1_q >>> FRAC_BITS) + SW'(t2_q >>> FRAC_BITS);

  always_ff @(posedge clk_i) begin
    if (en_i[ST_SP]) begin
      sp_q <= s_sum * signed'({1'b0, phi3_q});
    end
  end

  // phi/4 folded into the final shift
  assign corr_o = SW'(sp_q >>> (FRAC_BITS + 2));

  logic unused_rst;
  assign unused_rst = rst_ni;

endmodule

// ===== rtl/muscl_van_albada_face_values_core.sv =====
// MUSCL face reconstruction with the van Albada limiter, signed fixed point
// with FRAC_BITS fraction bits (Q16.16 by default). One face/variable item enters
// per cycle while the output is not stalled; the pipeline depth is set by the
// limiter quotient, which is built one bit per pipeline stage. Stalls on the
// output only hold items in place; empty stages ahead of a stalled item still
// take new input. Write kappa (index 0) and limiter_epsilon (index 1) only
// while no item is in flight.
`include "muscl_van_albada_face_values_core_defines.svh"

module muscl_van_albada_face_values_core #(
  parameter int FRAC_BITS = mvaf_pkg::FRAC_BITS_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // configuration
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [mvaf_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [mvaf_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  // input stream
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // left_value, right_value, offset_x, offset_y,
  // left_grad_x, left_grad_y, right_grad_x, right_grad_y
  input  logic [255:0]                        s_axis_tdata,
  // face_is_boundary
  input  logic                                s_axis_tuser,
  // output stream
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // left_face_value, right_face_value
  output logic [63:0]                         m_axis_tdata,
  // right_valid
  output logic                                m_axis_tuser
);

  localparam int NS  = FRAC_BITS + 9;
  localparam int DTW = 67 - FRAC_BITS;
  localparam int WK  = ((FRAC_BITS > 17) ? FRAC_BITS : 17) + 2;
  localparam int SW  = WK + 34 - FRAC_BITS;
  localparam int VW  = mvaf_pkg::VAL_W;

  // configuration registers
  logic signed [mvaf_pkg::KAPPA_W-1:0] kappa_q;
  logic [mvaf_pkg::EPS_W-1:0]          eps_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kappa_q <= mvaf_pkg::KAPPA_RST;
      eps_q   <= mvaf_pkg::EPS_RST;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        mvaf_pkg::REG_KAPPA: kappa_q <= signed'(cfg_data_i);
        mvaf_pkg::REG_EPS:   eps_q   <= cfg_data_i[mvaf_pkg::EPS_W-1:0];
        default:             eps_q   <= eps_q;
      endcase
    end
  end

  // stage valids; a stage moves when it is empty or the next one moves
  logic [NS-1:0] v_q, en;

  assign en[NS-1] = !v_q[NS-1] || m_axis_tready;
  for (genvar k = 0; k < NS - 1; k++) begin : g_en
    assign en[k] = !v_q[k] || en[k+1];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (en[0]) v_q[0] <= s_axis_tvalid;
      for (int k = 1; k < NS; k++) begin
        if (en[k]) v_q[k] <= v_q[k-1];
      end
    end
  end

  assign s_axis_tready = en[0];
  assign m_axis_tvalid = v_q[NS-1];

  // cell values and boundary flag travel alongside
  logic signed [VW-1:0] ui_q  [NS-1];
  logic signed [VW-1:0] uj_q  [NS-1];
  logic                 bnd_q [NS-1];
  logic signed [VW-1:0] ox_q, oy_q, lgx_q, lgy_q, rgx_q, rgy_q;

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      ui_q[0]  <= s_axis_tdata[31:0];
      uj_q[0]  <= s_axis_tdata[63:32];
      ox_q     <= s_axis_tdata[95:64];
      oy_q     <= s_axis_tdata[127:96];
      lgx_q    <= s_axis_tdata[159:128];
      lgy_q    <= s_axis_tdata[191:160];
      rgx_q    <= s_axis_tdata[223:192];
      rgy_q    <= s_axis_tdata[255:224];
      bnd_q[0] <= s_axis_tuser;
    end
  end

  for (genvar k = 1; k < NS - 1; k++) begin : g_line
    always_ff @(posedge clk_i) begin
      if (en[k]) begin
        ui_q[k]  <= ui_q[k-1];
        uj_q[k]  <= uj_q[k-1];
        bnd_q[k] <= bnd_q[k-1];
      end
    end
  end

  // gradient dot offset products
  logic signed [63:0] plx_q, ply_q, prx_q, pry_q;
  logic signed [VW:0] du1_q, du2_q;

  always_ff @(posedge clk_i) begin
    if (en[1]) begin
      du1_q <= (VW+1)'(uj_q[0]) - (VW+1)'(ui_q[0]);
      plx_q <= lgx_q * ox_q;
      ply_q <= lgy_q * oy_q;
      prx_q <= rgx_q * ox_q;
      pry_q <= rgy_q * oy_q;
    end
  end

  // biased differences
  logic signed [DTW-1:0] dot_l, dot_r, bl, br;
  logic signed [VW-1:0]  dl_q, dr_q;

  assign dot_l = DTW'(plx_q >>> FRAC_BITS) + DTW'(ply_q >>> FRAC_BITS);
  assign dot_r = DTW'(prx_q >>> FRAC_BITS) + DTW'(pry_q >>> FRAC_BITS);
  assign bl    = (dot_l <<< 1) - DTW'(du1_q);
  assign br    = (dot_r <<< 1) - DTW'(du1_q);

  always_ff @(posedge clk_i) begin
    if (en[2]) begin
      dl_q  <= mvaf_pkg::sat_val(64'(bl));
      dr_q  <= mvaf_pkg::sat_val(64'(br));
      du2_q <= du1_q;
    end
  end

  logic signed [SW-1:0] corr_l, corr_r;

  mvaf_side #(.FRAC_BITS(FRAC_BITS)) u_side_l (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en[FRAC_BITS+7:3]),
    .kappa_i (kappa_q),
    .eps_i   (eps_q),
    .d_i     (dl_q),
    .du_i    (du2_q),
    .corr_o  (corr_l)
  );

  mvaf_side #(.FRAC_BITS(FRAC_BITS)) u_side_r (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en[FRAC_BITS+7:3]),
    .kappa_i (kappa_q),
    .eps_i   (eps_q),
    .d_i     (dr_q),
    .du_i    (du2_q),
    .corr_o  (corr_r)
  );

  // output register
  logic signed [SW:0]   lsum, rsum;
  logic signed [VW-1:0] lf_q, rf_q;
  logic                 rv_q;

  assign lsum = (SW+1)'(ui_q[NS-2]) + (SW+1)'(corr_l);
  assign rsum = (SW+1)'(uj_q[NS-2]) - (SW+1)'(corr_r);

  always_ff @(posedge clk_i) begin
    if (en[NS-1]) begin
      lf_q <= mvaf_pkg::sat_val(64'(lsum));
      rf_q <= bnd_q[NS-2] ? '0 : mvaf_pkg::sat_val(64'(rsum));
      rv_q <= !bnd_q[NS-2];
    end
  end

  assign m_axis_tdata = {rf_q, lf_q};
  assign m_axis_tuser = rv_q;

  `MVAF_ASSERT(a_ghost_zero, m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata[63:32] == '0, "right face value not zero on boundary face")
  `MVAF_ASSERT(a_ready_when_empty, !v_q[NS-1] |-> s_axis_tready, "input stalled with empty output stage")
  `MVAF_ASSERT(a_result_kept, v_q[NS-1] && !m_axis_tready |=> v_q[NS-1], "result lost while stalled")
  `MVAF_ASSERT_ALWAYS(a_reset_empty, !rst_ni |=> !m_axis_tvalid, "output valid straight after reset")

endmodule
